// ----- rtl/core/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg: shared types and constants
// Widths, status codes and the controller-to-datapath command set for the
// binomial coefficient core.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int unsigned TableDepth = 65536;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned DataW      = 31;
  localparam int unsigned ArgW       = 16;
  localparam logic [DataW-1:0] ModulusReset = 31'd1000000007;

  localparam logic [1:0] RegModulus = 2'd0;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusRange    = 2'd1;
  localparam logic [1:0] StatusNotBuilt = 2'd2;

  localparam logic ActionBuild = 1'b0;
  localparam logic ActionQuery = 1'b1;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,       // latch request arguments, clear counters
    CMD_BUILD_INIT, // f = 1 mod m, write entry 0
    CMD_BUILD_MUL,  // start f * i
    CMD_BUILD_WR,   // write f into entry i, advance i
    CMD_RD_N,       // issue table read of entry n
    CMD_RD_R,       // issue read of entry r, capture fact[n]
    CMD_RD_NR,      // issue read of entry n-r, capture fact[r]
    CMD_CAP_NR,     // capture fact[n-r], set up exponentiation
    CMD_EXP_MUL,    // start next exponentiation product
    CMD_EXP_ADV,    // take product, step exponent
    CMD_FIN_MUL1,   // start fn * inv_r
    CMD_FIN_MUL2    // start t * inv_nr
  } cmd_t;

  typedef struct packed {
    logic mul_done;   // modular multiplier finished
    logic build_last; // index reached the last entry
    logic exp_last;   // exponent walk finished
    logic exp_second; // working on the second inverse
  } status_t;

endpackage

// ----- rtl/core/bmp_modmul.sv -----
// ----------------------------------------------------------------------------
// bmp_modmul: iterative modular multiplier
// Computes a*b mod m by shift-and-add, one multiplier bit per cycle, with a
// conditional subtract after each doubling and each addition.
// ----------------------------------------------------------------------------
module bmp_modmul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bmp_pkg::DataW-1:0] a,
  input  logic [bmp_pkg::DataW-1:0] b,
  input  logic [bmp_pkg::DataW-1:0] m,
  output logic                      done,
  output logic [bmp_pkg::DataW-1:0] prod
);

  localparam int unsigned CntW = $clog2(bmp_pkg::DataW + 1);

  logic [bmp_pkg::DataW-1:0] acc_r, acc_nxt;
  logic [bmp_pkg::DataW-1:0] a_r, a_nxt;
  logic [bmp_pkg::DataW-1:0] b_r, b_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [bmp_pkg::DataW:0]   dbl;
  logic [bmp_pkg::DataW-1:0] dbl_red;
  logic [bmp_pkg::DataW:0]   sum;
  logic [bmp_pkg::DataW-1:0] sum_red;

  // Operand a is already below m; acc < m throughout.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? bmp_pkg::DataW'(dbl - {1'b0, m})
                                 : dbl[bmp_pkg::DataW-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, a_r};
    sum_red = (sum >= {1'b0, m}) ? bmp_pkg::DataW'(sum - {1'b0, m})
                                 : sum[bmp_pkg::DataW-1:0];
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = CntW'(bmp_pkg::DataW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[bmp_pkg::DataW-1] ? sum_red : dbl_red;
      b_nxt   = {b_r[bmp_pkg::DataW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- rtl/core/bmp_datapath.sv -----
// ----------------------------------------------------------------------------
// bmp_datapath: factorial table, argument registers and exponentiation
// Holds the factorial memory, the shared modular multiplier and the
// square-and-multiply registers, all steered by commands from the controller.
// ----------------------------------------------------------------------------
module bmp_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bmp_pkg::cmd_t             cmd,
  input  logic [bmp_pkg::ArgW-1:0]  n_in,
  input  logic [bmp_pkg::ArgW-1:0]  r_in,
  input  logic [bmp_pkg::DataW-1:0] modulus,
  output bmp_pkg::status_t          status,
  output logic [bmp_pkg::DataW-1:0] result
);

  localparam int unsigned AW = bmp_pkg::AddrW;
  localparam int unsigned DW = bmp_pkg::DataW;
  localparam int unsigned BitW = $clog2(DW + 1);

  logic [DW-1:0] mem [bmp_pkg::TableDepth];
  logic [DW-1:0] rd_data_r;

  logic [DW-1:0] m_eff;
  logic [DW-1:0] expo;

  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] r_r, r_nxt;
  logic [DW-1:0] f_r, f_nxt;
  logic [DW-1:0] fn_r, fn_nxt;
  logic [DW-1:0] fr_r, fr_nxt;
  logic [DW-1:0] fnr_r, fnr_nxt;
  logic [DW-1:0] base_r, base_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] inv_r_r, inv_r_nxt;
  logic [BitW-1:0] bit_r, bit_nxt;
  logic          sq_r, sq_nxt;     // square phase of the current bit
  logic          second_r, second_nxt;
  logic [DW-1:0] res_r, res_nxt;

  logic          mul_start;
  logic [DW-1:0] mul_a, mul_b, prod;
  logic          mul_done;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;

  logic [DW-1:0] rd_red;
  logic          ebit;

  assign m_eff = (modulus < DW'(2)) ? DW'(1) : modulus;
  assign expo  = (modulus < DW'(2)) ? '0 : DW'(modulus - DW'(2));
  // Table entries may be from an older modulus. They only ever enter the
  // multiplier as its b operand, which need not be below m.
  assign rd_red = rd_data_r;
  assign ebit   = expo[bit_r[BitW-1:0] < BitW'(DW) ? bit_r[$clog2(DW)-1:0] : '0];

  bmp_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (m_eff),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    r_nxt      = r_r;
    f_nxt      = f_r;
    fn_nxt     = fn_r;
    fr_nxt     = fr_r;
    fnr_nxt    = fnr_r;
    base_nxt   = base_r;
    acc_nxt    = acc_r;
    inv_r_nxt  = inv_r_r;
    bit_nxt    = bit_r;
    sq_nxt     = sq_r;
    second_nxt = second_r;
    res_nxt    = res_r;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = f_r;
    rd_en      = 1'b0;
    rd_addr    = n_r;
    case (cmd)
      bmp_pkg::CMD_LOAD: begin
        n_nxt      = AW'(n_in);
        r_nxt      = AW'(r_in);
        idx_nxt    = '0;
        res_nxt    = '0;
        second_nxt = 1'b0;
      end
      bmp_pkg::CMD_BUILD_INIT: begin
        f_nxt   = (m_eff == DW'(1)) ? '0 : DW'(1);
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = (m_eff == DW'(1)) ? '0 : DW'(1);
        idx_nxt = AW'(1);
      end
      bmp_pkg::CMD_BUILD_MUL: begin
        // f is below m, so i may go in unreduced on the b side.
        mul_start = 1'b1;
        mul_a     = f_r;
        mul_b     = DW'(idx_r);
      end
      bmp_pkg::CMD_BUILD_WR: begin
        f_nxt   = prod;
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = prod;
        idx_nxt = idx_r + 1'b1;
      end
      bmp_pkg::CMD_RD_N: begin
        rd_en   = 1'b1;
        rd_addr = n_r;
      end
      bmp_pkg::CMD_RD_R: begin
        rd_en   = 1'b1;
        rd_addr = r_r;
        fn_nxt  = rd_red;
      end
      bmp_pkg::CMD_RD_NR: begin
        rd_en   = 1'b1;
        rd_addr = AW'(n_r - r_r);
        fr_nxt  = rd_red;
      end
      bmp_pkg::CMD_CAP_NR: begin
        fnr_nxt  = rd_red;
        base_nxt = fr_r;
        acc_nxt  = (m_eff == DW'(1)) ? '0 : DW'(1);
        bit_nxt  = '0;
        sq_nxt   = 1'b0;
      end
      bmp_pkg::CMD_EXP_MUL: begin
        // Per bit: multiply acc*base (kept only if the bit is set), then square.
        // The accumulator is always reduced, so it takes the a side of the multiply.
        mul_start = 1'b1;
        mul_a     = sq_r ? base_r : acc_r;
        mul_b     = base_r;
      end
      bmp_pkg::CMD_EXP_ADV: begin
        if (sq_r) begin
          base_nxt = prod;
          sq_nxt   = 1'b0;
          bit_nxt  = bit_r + 1'b1;
        end else begin
          if (ebit) acc_nxt = prod;
          // The first product is one times the raw base, which leaves the
          // base reduced for the squarings.
          if (bit_r == '0) base_nxt = prod;
          sq_nxt = 1'b1;
        end
        if (sq_r && bit_r == BitW'(DW - 1)) begin
          if (!second_r) begin
            inv_r_nxt  = acc_r;
            second_nxt = 1'b1;
            base_nxt   = fnr_r;
            acc_nxt    = (m_eff == DW'(1)) ? '0 : DW'(1);
            bit_nxt    = '0;
          end
        end
      end
      bmp_pkg::CMD_FIN_MUL1: begin
        mul_start = 1'b1;
        mul_a     = inv_r_r;
        mul_b     = fn_r;
      end
      bmp_pkg::CMD_FIN_MUL2: begin
        mul_start = 1'b1;
        mul_a     = prod;
        mul_b     = acc_r;
        res_nxt   = '0;
      end
      default: begin
      end
    endcase
    if (cmd == bmp_pkg::CMD_NOP && mul_done) res_nxt = prod;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r    <= '0;
      sq_r     <= 1'b0;
      second_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      bit_r    <= bit_nxt;
      sq_r     <= sq_nxt;
      second_r <= second_nxt;
      idx_r    <= idx_nxt;
    end
    n_r     <= n_nxt;
    r_r     <= r_nxt;
    f_r     <= f_nxt;
    fn_r    <= fn_nxt;
    fr_r    <= fr_nxt;
    fnr_r   <= fnr_nxt;
    base_r  <= base_nxt;
    acc_r   <= acc_nxt;
    inv_r_r <= inv_r_nxt;
    res_r   <= res_nxt;
  end

  assign status.mul_done   = mul_done;
  assign status.build_last = (idx_r == AW'(bmp_pkg::TableDepth - 1));
  assign status.exp_last   = sq_r && (bit_r == BitW'(DW - 1));
  assign status.exp_second = second_r;
  assign result            = res_r;

endmodule

// ----- rtl/core/bmp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmp_ctrl: sequencing state machine
// Accepts requests, checks the arguments, steps the datapath through build
// or query and issues the one-cycle result strobe.
// ----------------------------------------------------------------------------
module bmp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     action,
  input  logic [bmp_pkg::ArgW-1:0] n_value,
  input  logic [bmp_pkg::ArgW-1:0] r_value,
  input  bmp_pkg::status_t         status,
  output bmp_pkg::cmd_t            cmd,
  output logic                     busy,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic                     out_zero
);

  typedef enum logic [3:0] {
    S_IDLE, S_B_INIT, S_B_MUL, S_B_WAIT, S_Q_RDN, S_Q_RDR, S_Q_RDNR, S_Q_CAP,
    S_E_MUL, S_E_WAIT, S_F_MUL1, S_F_WAIT1, S_F_WAIT2, S_F_OUT, S_DONE
  } state_t;

  state_t     state_r;
  logic       ready_r;
  logic       valid_r;
  logic [1:0] st_r;
  logic       zero_r;
  logic       range_bad;

  assign range_bad = (r_value > n_value) ||
                     (32'(n_value) >= 32'(bmp_pkg::TableDepth));

  always_comb begin
    cmd = bmp_pkg::CMD_NOP;
    case (state_r)
      S_IDLE:    cmd = start ? bmp_pkg::CMD_LOAD : bmp_pkg::CMD_NOP;
      S_B_INIT:  cmd = bmp_pkg::CMD_BUILD_INIT;
      S_B_MUL:   cmd = bmp_pkg::CMD_BUILD_MUL;
      S_B_WAIT:  cmd = status.mul_done ? bmp_pkg::CMD_BUILD_WR : bmp_pkg::CMD_NOP;
      S_Q_RDN:   cmd = bmp_pkg::CMD_RD_N;
      S_Q_RDR:   cmd = bmp_pkg::CMD_RD_R;
      S_Q_RDNR:  cmd = bmp_pkg::CMD_RD_NR;
      S_Q_CAP:   cmd = bmp_pkg::CMD_CAP_NR;
      S_E_MUL:   cmd = bmp_pkg::CMD_EXP_MUL;
      S_E_WAIT:  cmd = status.mul_done ? bmp_pkg::CMD_EXP_ADV : bmp_pkg::CMD_NOP;
      S_F_MUL1:  cmd = bmp_pkg::CMD_FIN_MUL1;
      S_F_WAIT1: cmd = status.mul_done ? bmp_pkg::CMD_FIN_MUL2 : bmp_pkg::CMD_NOP;
      default:   cmd = bmp_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
      valid_r <= 1'b0;
      st_r    <= bmp_pkg::StatusOk;
      zero_r  <= 1'b1;
    end else begin
      valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (action == bmp_pkg::ActionBuild) begin
              state_r <= S_B_INIT;
            end else if (!ready_r) begin
              st_r    <= bmp_pkg::StatusNotBuilt;
              zero_r  <= 1'b1;
              state_r <= S_DONE;
            end else if (range_bad) begin
              st_r    <= bmp_pkg::StatusRange;
              zero_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_Q_RDN;
            end
          end
        end
        S_B_INIT: state_r <= S_B_MUL;
        S_B_MUL:  state_r <= S_B_WAIT;
        S_B_WAIT: begin
          if (status.mul_done) begin
            if (status.build_last) begin
              ready_r <= 1'b1;
              st_r    <= bmp_pkg::StatusOk;
              zero_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_B_MUL;
            end
          end
        end
        S_Q_RDN:  state_r <= S_Q_RDR;
        S_Q_RDR:  state_r <= S_Q_RDNR;
        S_Q_RDNR: state_r <= S_Q_CAP;
        S_Q_CAP:  state_r <= S_E_MUL;
        S_E_MUL:  state_r <= S_E_WAIT;
        S_E_WAIT: begin
          if (status.mul_done) begin
            if (status.exp_last && status.exp_second) state_r <= S_F_MUL1;
            else state_r <= S_E_MUL;
          end
        end
        S_F_MUL1:  state_r <= S_F_WAIT1;
        S_F_WAIT1: if (status.mul_done) state_r <= S_F_WAIT2;
        S_F_WAIT2: begin
          if (status.mul_done) begin
            st_r    <= bmp_pkg::StatusOk;
            zero_r  <= 1'b0;
            state_r <= S_F_OUT;
          end
        end
        S_F_OUT: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = valid_r;
  assign out_status = st_r;
  assign out_zero   = zero_r;

endmodule

// ----- rtl/core/binomial_mod_prime_core.sv -----
// ----------------------------------------------------------------------------
// binomial_mod_prime_core: n choose r modulo a prime
// Factorial table with Fermat inverses on a shared bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage: raise start with in_action, in_n_value and in_r_value while busy is
// low; the request is taken at that edge and busy rises. A build request
// (action 0) fills all 65536 table entries. A query (action 1) reads three
// entries, runs two 31-bit square-and-multiply exponentiations and two final
// products on the one modular multiplier. Checked errors answer without
// using the multiplier. Exactly one result per request appears on out_result
// and out_status for one cycle with out_valid high; the receiver cannot
// stall it. Reset clears the table-built flag and sets the modulus register
// to 1000000007; table contents are not cleared. The modulus is written
// through the cfg_ APB port at address 0; the user must write it only while
// the core is idle, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
module binomial_mod_prime_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_n_value,
  input  logic [15:0] in_r_value,
  output logic        out_valid,
  output logic [30:0] out_result,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [bmp_pkg::DataW-1:0] modulus_r;
  bmp_pkg::cmd_t             cmd;
  bmp_pkg::status_t          status;
  logic [bmp_pkg::DataW-1:0] dp_result;
  logic                      zero;
  logic                      req;

  assign req = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= bmp_pkg::ModulusReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == bmp_pkg::RegModulus) begin
      modulus_r <= cfg_pwdata[bmp_pkg::DataW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == bmp_pkg::RegModulus) ? {1'b0, modulus_r} : 32'd0;

  bmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (req),
    .action     (in_action),
    .n_value    (in_n_value),
    .r_value    (in_r_value),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_zero   (zero)
  );

  bmp_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .n_in    (in_n_value),
    .r_in    (in_r_value),
    .modulus (modulus_r),
    .status  (status),
    .result  (dp_result)
  );

  assign out_result = zero ? '0 : dp_result;

endmodule
